[rtl/rc_pkg.sv]
// Shared constants and types for the rank compression block.
package rc_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int VALUE_W   = 32;
	localparam int RANK_W    = 6;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	// A value travelling along the chain, with the count of smaller held values it has met.
	typedef struct packed {
		logic                      vld;
		logic signed [VALUE_W-1:0] val;
		logic [RANK_W-1:0]         cnt;
	} rc_tok_t;

	// What a cell shows its left-hand neighbour while the run is shifted out.
	typedef struct packed {
		logic              occ;
		logic [RANK_W-1:0] rank;
	} rc_slot_t;

	// Control from the sequencer to every cell.
	typedef struct packed {
		logic shift;
	} rc_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_DRAIN = 3'b010,
		ST_EMIT  = 3'b100
	} rc_state_t;

endpackage

[rtl/rc_in_if.sv]
// Input channel carrying one sequence element per item.
interface rc_in_if import rc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

[rtl/rc_out_if.sv]
// Output channel carrying one rank per item.
interface rc_out_if import rc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic              overflow;
	logic              end_of_run;

	modport source (output valid, output rank, output overflow, output end_of_run, input ready);
	modport sink (input valid, input rank, input overflow, input end_of_run, output ready);
endinterface

[rtl/rc_cell.sv]
// One cell of the ranking chain: holds a value and its running rank.
module rc_cell import rc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rc_ctl_t  ctl,
	input  rc_tok_t  tok_in,
	output rc_tok_t  tok_out,
	input  rc_slot_t nxt,
	output rc_slot_t slot
);

	logic                      occ_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [RANK_W-1:0]         rank_q;
	logic                      tok_vld_q;
	logic signed [VALUE_W-1:0] tok_val_q;
	logic [RANK_W-1:0]         tok_cnt_q;
	logic                      tok_smaller;
	logic                      held_smaller;

	assign tok_smaller  = tok_in.val < val_q;
	assign held_smaller = val_q < tok_in.val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			if (ctl.shift) begin
				occ_q <= nxt.occ;
			end else if (tok_in.vld && !occ_q) begin
				occ_q <= 1'b1;
			end
			// An item moves on only past an occupied cell; at the first free one it settles.
			tok_vld_q <= tok_in.vld && occ_q && !ctl.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rank_q <= nxt.rank;
		end else if (tok_in.vld) begin
			if (!occ_q) begin
				val_q  <= tok_in.val;
				rank_q <= tok_in.cnt;
			end else if (tok_smaller) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
		tok_val_q <= tok_in.val;
		tok_cnt_q <= tok_in.cnt + RANK_W'(held_smaller);
	end

	assign tok_out.vld = tok_vld_q;
	assign tok_out.val = tok_val_q;
	assign tok_out.cnt = tok_cnt_q;
	assign slot.occ    = occ_q;
	assign slot.rank   = rank_q;

endmodule

[rtl/rank_compression.sv]
// Top level of the rank compression block: sequencer and the chain of cells.
//
//   channel  direction  payload                          accepted when
//   items    in         value (s32), last                items.valid && items.ready
//   ranks    out        rank (6), overflow, end_of_run   ranks.valid && ranks.ready
//
// Loading takes one item per cycle; each value walks the chain one cell a cycle
// and settles in the first free cell, so after the last item the chain drains
// before the run is shifted out, one rank a cycle unless the ranks channel stalls.
// Items are not taken while the chain drains or the run is being emitted.
// A stalled ranks channel holds the chain still. Reset empties every cell at once.
module rank_compression import rc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rc_in_if.sink       items,
	rc_out_if.source    ranks
);

	rc_state_t            state_q;
	logic [CNT_W-1:0]     held_q;
	logic                 dropped_q;
	rc_ctl_t              ctl;
	rc_tok_t              tok [MAX_ITEMS+1];
	rc_slot_t             slot [MAX_ITEMS+1];
	logic [MAX_ITEMS-1:0] tok_busy;
	logic                 in_fire;
	logic                 out_fire;
	logic                 full;
	logic                 run_end;

	assign full     = held_q == CNT_W'(MAX_ITEMS);
	assign in_fire  = items.valid && items.ready;
	assign out_fire = ranks.valid && ranks.ready;
	assign run_end  = !slot[1].occ;

	assign items.ready = state_q == ST_LOAD;

	assign tok[0].vld = in_fire && !full;
	assign tok[0].val = items.value;
	assign tok[0].cnt = '0;

	assign slot[MAX_ITEMS].occ  = 1'b0;
	assign slot[MAX_ITEMS].rank = '0;

	assign ctl.shift = out_fire;

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		rc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.nxt     (slot[k+1]),
			.slot    (slot[k])
		);
		assign tok_busy[k] = tok[k+1].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			held_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							held_q <= held_q + CNT_W'(1);
						end
						if (items.last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!(|tok_busy)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_fire && run_end) begin
						state_q   <= ST_LOAD;
						held_q    <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign ranks.valid      = state_q == ST_EMIT;
	assign ranks.rank       = slot[0].rank;
	assign ranks.overflow   = dropped_q;
	assign ranks.end_of_run = run_end;

endmodule
